>>> hdl/cchm_pkg.sv
// shared constants and types for the coalesced hash map
`timescale 1ns / 1ps
`default_nettype none
package cchm_pkg;

  localparam int KEY_W = 32;
  localparam logic [KEY_W-1:0] EMPTY_KEY = 32'h8000_0000;

  typedef logic [1:0] cmd_t;
  typedef logic signed [KEY_W-1:0] word_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_LOOKUP = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

endpackage
`default_nettype wire

>>> hdl/cchm_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cchm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> hdl/cchm_home.sv
// home slot unit: |key| mod HASH_SLOTS by reciprocal multiply, folded into capacity
`timescale 1ns / 1ps
`default_nettype none
module cchm_home #(
  parameter int HASH_SLOTS = 10,
  parameter int CAPACITY   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cchm_pkg::KEY_W-1:0]  key_in,
  output      logic                        done,
  output      logic [$clog2(CAPACITY)-1:0] home
);
  import cchm_pkg::*;

  localparam int MAXD = (HASH_SLOTS > CAPACITY) ? HASH_SLOTS : CAPACITY;
  localparam int DW   = $clog2(MAXD) + 1;
  localparam int IW   = $clog2(CAPACITY);
  localparam int PW   = 2 * KEY_W;

  // floor(2^32 / d) clipped to 32 bits: the quotient estimate is low by at most one
  function automatic logic [KEY_W-1:0] recip(input int d);
    logic [PW-1:0] q;
    q = (PW'(1) << KEY_W) / PW'(d);
    return ((q >> KEY_W) != '0) ? '1 : q[KEY_W-1:0];
  endfunction

  localparam logic [KEY_W-1:0] RCP_HASH = recip(HASH_SLOTS);
  localparam logic [KEY_W-1:0] RCP_CAP  = recip(CAPACITY);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_SUB  = 4'b0100,
    H_FIX  = 4'b1000
  } home_state_t;

  home_state_t       state_r, state_nxt;
  logic              pass2_r, pass2_nxt;
  logic              done_r, done_nxt;
  logic [KEY_W-1:0]  mag_r, mag_nxt;
  logic [KEY_W-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [IW-1:0]     home_r, home_nxt;
  logic [KEY_W-1:0]  divisor;
  logic [KEY_W-1:0]  rcp;
  logic [PW-1:0]     prod;
  logic [KEY_W-1:0]  diff;
  logic [DW-1:0]     rem_fix;

  // one multiply, one subtract, one correction, registered in turn by H_MUL, H_SUB and H_FIX
  always_comb begin
    divisor = pass2_r ? KEY_W'(CAPACITY) : KEY_W'(HASH_SLOTS);
    rcp     = pass2_r ? RCP_CAP : RCP_HASH;
    prod    = PW'(mag_r) * PW'(rcp);
    diff    = mag_r - quo_r * divisor;
    rem_fix = (rem_r >= divisor[DW-1:0]) ? (rem_r - divisor[DW-1:0]) : rem_r;
  end

  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    done_nxt  = 1'b0;
    mag_nxt   = mag_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    home_nxt  = home_r;
    if (start) begin
      state_nxt = H_MUL;
      pass2_nxt = 1'b0;
      mag_nxt   = key_in[KEY_W-1] ? (~key_in + KEY_W'(1)) : key_in;
    end else begin
      case (state_r)
        H_MUL: begin
          quo_nxt   = prod[PW-1:KEY_W];
          state_nxt = H_SUB;
        end
        H_SUB: begin
          // remainder is below twice the divisor here
          rem_nxt   = diff[DW-1:0];
          state_nxt = H_FIX;
        end
        H_FIX: begin
          if (!pass2_r && rem_fix >= DW'(CAPACITY)) begin
            // home beyond capacity: reduce again by capacity
            pass2_nxt = 1'b1;
            mag_nxt   = KEY_W'(rem_fix);
            state_nxt = H_MUL;
          end else begin
            done_nxt  = 1'b1;
            home_nxt  = rem_fix[IW-1:0];
            state_nxt = H_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass2_r <= pass2_nxt;
    mag_r   <= mag_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    home_r  <= home_nxt;
  end

  assign done = done_r;
  assign home = home_r;

endmodule
`default_nettype wire

>>> hdl/coalesced_hash_map.sv
// top level: coalesced hash map sequencer around key/link and value memories
`timescale 1ns / 1ps
`default_nettype none
// Key-value table with coalesced chaining, CAPACITY slots.
// Input: raise start with in_cmd (insert, lookup, remove), in_key, in_data_in;
// the item is taken at a clock edge where start is high and busy is low.
// Result: out_valid is high for one cycle with out_found, out_data_out,
// out_full_res and out_count; the receiver has to take it in that cycle.
// One item is worked on at a time; busy stays high until its result is out.
// Work per item: a home computation (a second pass if the home folds past
// CAPACITY), a read and a compare per chain slot visited, a read and a
// check per slot of a first-free rescan, plus the value access. A remove
// also hashes each later chain member after its read and, when the key
// sits in its home slot with nothing moved, scans the link memory for the
// predecessor. The single-port key/link memory sets the pace of chain
// walks and scans. After reset the key/link memory is cleared, one slot
// a cycle, with busy high; the table then holds no pairs.
module coalesced_hash_map #(
  parameter int CAPACITY   = 16,
  parameter int HASH_SLOTS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire cchm_pkg::cmd_t        in_cmd,
  input  wire cchm_pkg::word_t       in_key,
  input  wire cchm_pkg::word_t       in_data_in,
  output      logic                  out_valid,
  output      logic                  out_found,
  output      cchm_pkg::word_t       out_data_out,
  output      logic                  out_full_res,
  output      logic [4:0]            out_count
);
  import cchm_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = KEY_W + LW;
  localparam logic [LW-1:0] NONE  = LW'(CAPACITY);
  localparam logic [IW-1:0] LASTI = IW'(CAPACITY - 1);

  typedef enum logic [25:0] {
    S_CLEAR   = 26'b1 << 0,
    S_IDLE    = 26'b1 << 1,
    S_HASH    = 26'b1 << 2,
    S_WALK_RD = 26'b1 << 3,
    S_WALK    = 26'b1 << 4,
    S_MISS    = 26'b1 << 5,
    S_LNK_RD  = 26'b1 << 6,
    S_LNK     = 26'b1 << 7,
    S_FREE_RD = 26'b1 << 8,
    S_FREE    = 26'b1 << 9,
    S_VAL_RD  = 26'b1 << 10,
    S_VAL     = 26'b1 << 11,
    S_MV_RD   = 26'b1 << 12,
    S_MV      = 26'b1 << 13,
    S_MV_H    = 26'b1 << 14,
    S_MVV_RD  = 26'b1 << 15,
    S_MVV     = 26'b1 << 16,
    S_FIN     = 26'b1 << 17,
    S_PS_RD   = 26'b1 << 18,
    S_PS      = 26'b1 << 19,
    S_FI_RD   = 26'b1 << 20,
    S_FI      = 26'b1 << 21,
    S_FJ_RD   = 26'b1 << 22,
    S_FJ      = 26'b1 << 23,
    S_FC      = 26'b1 << 24,
    S_DONE    = 26'b1 << 25
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     sc_r, sc_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  val_r, val_nxt;
  logic [IW-1:0]     h_r, h_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [LW-1:0]     j_r, j_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic [LW-1:0]     m_r, m_nxt;
  logic [LW-1:0]     mv_r, mv_nxt;
  logic [IW-1:0]     p_r, p_nxt;
  logic [IW-1:0]     pp_r, pp_nxt;
  logic [LW-1:0]     ilink_r, ilink_nxt;
  logic [LW-1:0]     plink_r, plink_nxt;
  logic [KEY_W-1:0]  pkey_r, pkey_nxt;
  logic [LW-1:0]     ff_r, ff_nxt;
  logic [LW-1:0]     pt_r, pt_nxt;
  logic              found_r, found_nxt;
  logic [KEY_W-1:0]  dout_r, dout_nxt;
  logic              full_r, full_nxt;

  // memory ports
  logic              a_we, b_we;
  logic [IW-1:0]     a_addr, b_addr;
  logic [AW-1:0]     a_wdata, a_rdata;
  logic [KEY_W-1:0]  b_wdata, b_rdata;
  logic [KEY_W-1:0]  rkey;
  logic [LW-1:0]     rlink;

  // home unit
  logic              h_start, h_done;
  logic [KEY_W-1:0]  h_key;
  logic [IW-1:0]     h_home;

  logic              in_ok;
  logic              home_ins;

  assign rkey  = a_rdata[KEY_W-1:0];
  assign rlink = a_rdata[AW-1:KEY_W];
  assign in_ok = (in_key != EMPTY_KEY) &&
                 (in_cmd == CMD_INSERT || in_cmd == CMD_LOOKUP || in_cmd == CMD_REMOVE);
  assign home_ins = (cmd_r == CMD_INSERT) && (n_r == '0) && (rkey == EMPTY_KEY);

  assign h_start = (state_r == S_IDLE && start && in_ok) || (state_r == S_MV);
  assign h_key   = (state_r == S_IDLE) ? in_key : rkey;

  cchm_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (a_we),
    .addr  (a_addr),
    .wdata (a_wdata),
    .rdata (a_rdata)
  );

  cchm_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (b_we),
    .addr  (b_addr),
    .wdata (b_wdata),
    .rdata (b_rdata)
  );

  cchm_home #(.HASH_SLOTS(HASH_SLOTS), .CAPACITY(CAPACITY)) u_home (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (h_start),
    .key_in (h_key),
    .done   (h_done),
    .home   (h_home)
  );

  // memory access per state
  always_comb begin
    a_we    = 1'b0;
    a_addr  = i_r;
    a_wdata = {NONE, EMPTY_KEY};
    b_we    = 1'b0;
    b_addr  = i_r;
    b_wdata = val_r;
    case (state_r)
      S_CLEAR: begin
        a_addr = sc_r;
        a_we   = 1'b1;
      end
      S_WALK: begin
        if (home_ins) begin
          a_we    = 1'b1;
          a_wdata = {rlink, key_r};
          b_we    = 1'b1;
        end
      end
      S_MISS: begin
        a_addr = ff_r[IW-1:0];
        b_addr = ff_r[IW-1:0];
        if (cmd_r == CMD_INSERT && ff_r < NONE) begin
          a_we    = 1'b1;
          a_wdata = {NONE, key_r};
          b_we    = 1'b1;
        end
      end
      S_LNK_RD: a_addr = j_r[IW-1:0];
      S_LNK: begin
        a_addr  = j_r[IW-1:0];
        a_we    = 1'b1;
        a_wdata = {ff_r, rkey};
      end
      S_FREE_RD: a_addr = sc_r;
      S_VAL: b_we = (cmd_r == CMD_INSERT);
      S_MV_RD: a_addr = p_r;
      S_MVV_RD: b_addr = p_r;
      S_MVV: begin
        a_we    = 1'b1;
        a_wdata = {ilink_r, pkey_r};
        b_we    = 1'b1;
        b_wdata = b_rdata;
      end
      S_PS_RD: a_addr = sc_r;
      S_FJ_RD: a_addr = j_r[IW-1:0];
      S_FJ: begin
        a_addr  = j_r[IW-1:0];
        a_we    = 1'b1;
        a_wdata = {ilink_r, rkey};
      end
      S_FC: a_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sc_nxt    = sc_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    h_nxt     = h_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    mv_nxt    = mv_r;
    p_nxt     = p_r;
    pp_nxt    = pp_r;
    ilink_nxt = ilink_r;
    plink_nxt = plink_r;
    pkey_nxt  = pkey_r;
    ff_nxt    = ff_r;
    pt_nxt    = pt_r;
    found_nxt = found_r;
    dout_nxt  = dout_r;
    full_nxt  = full_r;
    case (state_r)
      S_CLEAR: begin
        sc_nxt = sc_r + IW'(1);
        if (sc_r == LASTI) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key;
          val_nxt   = in_data_in;
          found_nxt = 1'b0;
          dout_nxt  = '0;
          full_nxt  = 1'b0;
          state_nxt = in_ok ? S_HASH : S_DONE;
        end
      end
      S_HASH: begin
        if (h_done) begin
          h_nxt     = h_home;
          i_nxt     = h_home;
          n_nxt     = '0;
          j_nxt     = NONE;
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: state_nxt = S_WALK;
      S_WALK: begin
        if (home_ins) begin
          pt_nxt = pt_r + LW'(1);
          if (LW'(i_r) == ff_r) begin
            sc_nxt    = i_r;
            state_nxt = S_FREE_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (rkey == key_r) begin
          ilink_nxt = rlink;
          state_nxt = S_VAL_RD;
        end else if (n_r == NONE) begin
          // walk ran CAPACITY steps without a hit
          state_nxt = S_MISS;
        end else begin
          j_nxt = LW'(i_r);
          if (rlink >= NONE) begin
            state_nxt = S_MISS;
          end else begin
            i_nxt     = rlink[IW-1:0];
            n_nxt     = n_r + LW'(1);
            state_nxt = S_WALK_RD;
          end
        end
      end
      S_MISS: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_INSERT) begin
          if (ff_r < NONE) begin
            pt_nxt = pt_r + LW'(1);
            sc_nxt = ff_r[IW-1:0];
            state_nxt = (j_r < NONE) ? S_LNK_RD : S_FREE_RD;
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      S_LNK_RD: state_nxt = S_LNK;
      S_LNK: state_nxt = S_FREE_RD;
      S_FREE_RD: state_nxt = S_FREE;
      S_FREE: begin
        if (rkey == EMPTY_KEY) begin
          ff_nxt    = LW'(sc_r);
          state_nxt = S_DONE;
        end else if (sc_r == LASTI) begin
          ff_nxt    = NONE;
          state_nxt = S_DONE;
        end else begin
          sc_nxt    = sc_r + IW'(1);
          state_nxt = S_FREE_RD;
        end
      end
      S_VAL_RD: state_nxt = S_VAL;
      S_VAL: begin
        found_nxt = 1'b1;
        dout_nxt  = b_rdata;
        state_nxt = S_DONE;
        if (cmd_r == CMD_REMOVE) begin
          mv_nxt = '0;
          m_nxt  = '0;
          pp_nxt = i_r;
          if (ilink_r >= NONE) begin
            state_nxt = S_FIN;
          end else begin
            p_nxt     = ilink_r[IW-1:0];
            state_nxt = S_MV_RD;
          end
        end
      end
      S_MV_RD: state_nxt = S_MV;
      S_MV: begin
        pkey_nxt  = rkey;
        plink_nxt = rlink;
        state_nxt = S_MV_H;
      end
      S_MV_H: begin
        if (h_done) begin
          if (h_home == i_r) begin
            state_nxt = S_MVV_RD;
          end else if (m_r == NONE) begin
            state_nxt = S_FIN;
          end else begin
            pp_nxt = p_r;
            if (plink_r >= NONE) begin
              state_nxt = S_FIN;
            end else begin
              p_nxt     = plink_r[IW-1:0];
              m_nxt     = m_r + LW'(1);
              state_nxt = S_MV_RD;
            end
          end
        end
      end
      S_MVV_RD: state_nxt = S_MVV;
      S_MVV: begin
        // member moved into the hole, the hole moves on to its old slot
        i_nxt     = p_r;
        ilink_nxt = plink_r;
        j_nxt     = LW'(pp_r);
        mv_nxt    = mv_r + LW'(1);
        pp_nxt    = p_r;
        m_nxt     = '0;
        if (mv_r + LW'(1) == NONE || plink_r >= NONE) begin
          state_nxt = S_FIN;
        end else begin
          p_nxt     = plink_r[IW-1:0];
          state_nxt = S_MV_RD;
        end
      end
      S_FIN: begin
        sc_nxt    = '0;
        state_nxt = (j_r >= NONE) ? S_PS_RD : S_FI_RD;
      end
      S_PS_RD: state_nxt = S_PS;
      S_PS: begin
        // predecessor of the home slot
        if (rlink == LW'(h_r)) begin
          j_nxt     = LW'(sc_r);
          state_nxt = S_FI_RD;
        end else if (sc_r == LASTI) begin
          state_nxt = S_FI_RD;
        end else begin
          sc_nxt    = sc_r + IW'(1);
          state_nxt = S_PS_RD;
        end
      end
      S_FI_RD: state_nxt = S_FI;
      S_FI: begin
        ilink_nxt = rlink;
        state_nxt = (j_r < NONE) ? S_FJ_RD : S_FC;
      end
      S_FJ_RD: state_nxt = S_FJ;
      S_FJ: state_nxt = S_FC;
      S_FC: begin
        if (ff_r > LW'(i_r)) begin
          ff_nxt = LW'(i_r);
        end
        if (pt_r != '0) begin
          pt_nxt = pt_r - LW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sc_r    <= '0;
      ff_r    <= '0;
      pt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      ff_r    <= ff_nxt;
      pt_r    <= pt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    h_r     <= h_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    mv_r    <= mv_nxt;
    p_r     <= p_nxt;
    pp_r    <= pp_nxt;
    ilink_r <= ilink_nxt;
    plink_r <= plink_nxt;
    pkey_r  <= pkey_nxt;
    found_r <= found_nxt;
    dout_r  <= dout_nxt;
    full_r  <= full_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_DONE);
  assign out_found    = found_r;
  assign out_data_out = dout_r;
  assign out_full_res = full_r;
  assign out_count    = 5'(pt_r);

endmodule
`default_nettype wire

>>> hdl/cchm_chk.sv
// port-level checker for the coalesced hash map, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module cchm_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic                  out_found,
  input wire cchm_pkg::word_t       out_data_out,
  input wire logic                  out_full_res
);
  import cchm_pkg::*;

  // an accepted item keeps the block busy until its result is out
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_res) |-> !out_found)
    else $error("refused insert reported a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_data_out == '0))
    else $error("miss with nonzero data");

endmodule

bind coalesced_hash_map cchm_chk u_cchm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_found    (out_found),
  .out_data_out (out_data_out),
  .out_full_res (out_full_res)
);
`default_nettype wire
